### design/ps2mpc_pkg.sv
// Shared constants and types for the PS/2 mouse packet cursor block.
// Used by ps2mpc_clamp and ps2_mouse_packet_cursor; no dependencies.
package ps2mpc_pkg;

    // Coordinate and resolution width
    localparam int COORD_W = 12;
    localparam int DELTA_W = 9;
    // Widened signed width for position plus movement
    localparam int SUM_W   = COORD_W + 2;
    // Movement step as fed to the clamp (negated Y needs one more bit)
    localparam int STEP_W  = DELTA_W + 1;

    localparam int DEFAULT_POSITION_WIDTH = 12;

    localparam logic [COORD_W-1:0] X_RES_RESET = 12'd1024;
    localparam logic [COORD_W-1:0] Y_RES_RESET = 12'd768;

    // Clamp constants
    localparam logic [SUM_W-1:0] EDGE_MARGIN  = 14'd16;
    localparam logic [SUM_W-1:0] EDGE_BACKOFF = 14'd21;
    localparam logic [SUM_W-1:0] LOW_PARK     = 14'd5;

    // First-byte bit positions
    localparam int BIT_LEFT     = 0;
    localparam int BIT_RIGHT    = 1;
    localparam int BIT_MIDDLE   = 2;
    localparam int BIT_SYNC     = 3;
    localparam int BIT_X_SIGN   = 4;
    localparam int BIT_Y_SIGN   = 5;
    localparam int BIT_X_OVFL   = 6;
    localparam int BIT_Y_OVFL   = 7;

    // APB register map
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef enum logic {
        REG_X_RES = 1'b0,
        REG_Y_RES = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        IDX_FIRST  = 2'd0,
        IDX_SECOND = 2'd1,
        IDX_THIRD  = 2'd2,
        IDX_SPARE  = 2'd3
    } byte_index_t;

endpackage

### design/ps2mpc_clamp.sv
// One cursor coordinate: apply a signed step and clamp to the screen.
// Depends on ps2mpc_pkg for widths and clamp constants.
module ps2mpc_clamp
    import ps2mpc_pkg::*;
(
    input  logic        [COORD_W-1:0] pos,
    input  logic signed [STEP_W-1:0]  step,
    input  logic        [COORD_W-1:0] resolution,
    output logic        [COORD_W-1:0] pos_new
);

    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] low_fixed;
    logic signed [SUM_W-1:0] top;
    logic signed [SUM_W-1:0] backoff;

    always_comb begin
        sum       = $signed({2'b00, pos}) + SUM_W'(step);
        low_fixed = (sum < 0) ? $signed(LOW_PARK) : sum;
        top       = $signed({2'b00, resolution}) - $signed(EDGE_MARGIN);
        backoff   = $signed({2'b00, resolution}) - $signed(EDGE_BACKOFF);
        priority if (low_fixed > top) begin
            pos_new = (backoff < 0) ? '0 : backoff[COORD_W-1:0];
        end else begin
            pos_new = low_fixed[COORD_W-1:0];
        end
    end

endmodule

### design/ps2_mouse_packet_cursor.sv
// Top level of the PS/2 mouse packet decoder with cursor tracking.
// Depends on ps2mpc_pkg and ps2mpc_clamp.
//
// Usage:
//   s_ channel: one raw mouse byte per transfer on s_tdata.
//   m_ channel: one transfer per complete three-byte packet, carrying the
//   cursor position after the packet, the 9-bit deltas, buttons and
//   overflow flags.
//   APB port: x resolution at address 0, y resolution at address 4.
//   Write only while the block is idle.
// Bytes are dropped until one with bit 3 set arrives; from then on every
// three bytes form a packet. A packet with either overflow flag set leaves
// the cursor in place but still yields a transfer.
// Output: registered, on the m_ side in the cycle after the third byte is
// taken. Throughput: one byte per cycle while no third byte waits on a result,
// set by the single add-and-clamp stage in front of the result register.
// Reset: sync is lost, byte count and cursor go to zero, resolutions
// return to 1024 by 768, no result is pending.
// Stall: while a result waits, the first two bytes of the next packet are
// still taken; the third byte waits until the pending result is taken.
module ps2_mouse_packet_cursor
    import ps2mpc_pkg::*;
#(
    parameter int POSITION_WIDTH = DEFAULT_POSITION_WIDTH,
    localparam int OUT_BITS = 2*POSITION_WIDTH + 2*DELTA_W + 5,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // byte_in

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // cursor_x, cursor_y, delta_x, delta_y, left_button, right_button,
    // middle_button, x_overflow, y_overflow, zero pad
    output logic [OUT_W-1:0]      m_tdata,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [COORD_W-1:0] x_res_reg;
    logic [COORD_W-1:0] y_res_reg;
    logic               synced_reg;
    byte_index_t        byte_index_reg;
    byte_index_t        byte_index_next;
    logic [7:0]         first_byte_reg;
    logic [7:0]         second_byte_reg;
    logic [COORD_W-1:0] pos_x_reg;
    logic [COORD_W-1:0] pos_y_reg;
    logic [COORD_W-1:0] pos_x_next;
    logic [COORD_W-1:0] pos_y_next;
    logic               out_valid_reg;
    logic [OUT_W-1:0]   out_data_reg;
    logic [OUT_W-1:0]   out_data_next;

    logic               in_fire;
    logic               take;
    logic               complete;
    logic               cfg_write;
    reg_index_t         cfg_sel;

    logic signed [DELTA_W-1:0] delta_x;
    logic signed [DELTA_W-1:0] delta_y;
    logic signed [STEP_W-1:0]  step_x;
    logic signed [STEP_W-1:0]  step_y;
    logic [COORD_W-1:0]        clamp_x;
    logic [COORD_W-1:0]        clamp_y;
    logic                      x_ovfl;
    logic                      y_ovfl;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = reg_index_t'(paddr[2]);

    always_comb begin
        unique case (cfg_sel)
            REG_X_RES: prdata = APB_DATA_W'(x_res_reg);
            REG_Y_RES: prdata = APB_DATA_W'(y_res_reg);
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_res_reg <= X_RES_RESET;
            y_res_reg <= Y_RES_RESET;
        end else if (cfg_write) begin
            unique case (cfg_sel)
                REG_X_RES: x_res_reg <= pwdata[COORD_W-1:0];
                REG_Y_RES: y_res_reg <= pwdata[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // Only the packet-completing byte needs room in the result register
    assign s_tready = !out_valid_reg || m_tready || !byte_index_reg[1];
    assign in_fire  = s_tvalid && s_tready;
    assign take     = in_fire && (synced_reg || s_tdata[BIT_SYNC]);
    assign complete = take && byte_index_reg[1];

    always_comb begin
        unique case (byte_index_reg)
            IDX_FIRST:  byte_index_next = IDX_SECOND;
            IDX_SECOND: byte_index_next = IDX_THIRD;
            default:    byte_index_next = IDX_FIRST;
        endcase
    end

    // Decode the packet from the stored bytes and the byte being taken
    assign delta_x = $signed({first_byte_reg[BIT_X_SIGN], second_byte_reg});
    assign delta_y = $signed({first_byte_reg[BIT_Y_SIGN], s_tdata});
    assign x_ovfl  = first_byte_reg[BIT_X_OVFL];
    assign y_ovfl  = first_byte_reg[BIT_Y_OVFL];
    assign step_x  = STEP_W'(delta_x);
    assign step_y  = -STEP_W'(delta_y);

    ps2mpc_clamp u_clamp_x (
        .pos        (pos_x_reg),
        .step       (step_x),
        .resolution (x_res_reg),
        .pos_new    (clamp_x)
    );

    ps2mpc_clamp u_clamp_y (
        .pos        (pos_y_reg),
        .step       (step_y),
        .resolution (y_res_reg),
        .pos_new    (clamp_y)
    );

    always_comb begin
        // hold the cursor on overflow
        if (x_ovfl || y_ovfl) begin
            pos_x_next = pos_x_reg;
            pos_y_next = pos_y_reg;
        end else begin
            pos_x_next = clamp_x;
            pos_y_next = clamp_y;
        end
        out_data_next = OUT_W'({
            y_ovfl,
            x_ovfl,
            first_byte_reg[BIT_MIDDLE],
            first_byte_reg[BIT_RIGHT],
            first_byte_reg[BIT_LEFT],
            delta_y,
            delta_x,
            POSITION_WIDTH'(pos_y_next),
            POSITION_WIDTH'(pos_x_next)
        });
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            synced_reg     <= 1'b0;
            byte_index_reg <= IDX_FIRST;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (take) begin
                synced_reg     <= 1'b1;
                byte_index_reg <= byte_index_next;
            end
            if (complete) begin
                pos_x_reg     <= pos_x_next;
                pos_y_reg     <= pos_y_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (take && byte_index_reg == IDX_FIRST) begin
            first_byte_reg <= s_tdata;
        end
        if (take && byte_index_reg == IDX_SECOND) begin
            second_byte_reg <= s_tdata;
        end
        if (complete) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### tb/tb_ps2_mouse_packet_cursor.sv
// Self-checking testbench for ps2_mouse_packet_cursor: mouse bytes go in on the
// s_ stream, decoded packets come back on the m_ stream and are checked against
// an in-bench packet decoder. Depends on ps2mpc_pkg and the design sources.
module tb_ps2_mouse_packet_cursor
    import ps2mpc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int OUT_W = 48;

    typedef struct {
        logic [COORD_W-1:0] cursor_x;
        logic [COORD_W-1:0] cursor_y;
        logic [DELTA_W-1:0] delta_x;
        logic [DELTA_W-1:0] delta_y;
        logic               left_btn;
        logic               right_btn;
        logic               middle_btn;
        logic               x_ovfl;
        logic               y_ovfl;
    } mouse_packet_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;      // byte_in
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // cursor_x, cursor_y, delta_x, delta_y, left_button, right_button,
    // middle_button, x_overflow, y_overflow, zero pad
    logic [OUT_W-1:0]      m_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // decoder state mirrored in the bench
    logic                synced;
    byte_index_t         byte_idx;
    logic [7:0]          head_byte;
    logic [7:0]          x_byte;
    int                  pos_x;
    int                  pos_y;
    logic [COORD_W-1:0]  x_res;
    logic [COORD_W-1:0]  y_res;

    mouse_packet_t packets_due[$];
    int            mismatch_count = 0;
    bit            send_gaps = 1'b0;
    bit            recv_gaps = 1'b0;

    ps2_mouse_packet_cursor DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    task automatic report(string what, int got, int want);
        $display("%0t mismatch %s: got %0d (0x%0h) want %0d (0x%0h)",
                 $realtime, what, got, got, want, want);
        mismatch_count++;
    endtask

    function automatic int clamp_to_screen(int v, int res);
        int top;
        top = res - 16;
        if (v < 0) v = 5;
        if (v > top) begin
            v = res - 21;
            if (v < 0) v = 0;
        end
        return v;
    endfunction

    // Advance the decoder by one accepted byte; queue a packet when one completes.
    task automatic decode_mouse_byte(logic [7:0] b);
        mouse_packet_t pkt;
        int dx;
        int dy;
        if (!synced) begin
            if (!b[BIT_SYNC]) return;
            synced = 1'b1;
        end
        case (byte_idx)
            IDX_FIRST: begin
                head_byte = b;
                byte_idx = IDX_SECOND;
            end
            IDX_SECOND: begin
                x_byte = b;
                byte_idx = IDX_THIRD;
            end
            default: begin
                byte_idx = IDX_FIRST;
                dx = int'(x_byte) - (head_byte[BIT_X_SIGN] ? 256 : 0);
                dy = int'(b) - (head_byte[BIT_Y_SIGN] ? 256 : 0);
                if (!head_byte[BIT_X_OVFL] && !head_byte[BIT_Y_OVFL]) begin
                    pos_x = clamp_to_screen(pos_x + dx, int'(x_res));
                    pos_y = clamp_to_screen(pos_y - dy, int'(y_res));
                end
                pkt.cursor_x   = pos_x[COORD_W-1:0];
                pkt.cursor_y   = pos_y[COORD_W-1:0];
                pkt.delta_x    = {head_byte[BIT_X_SIGN], x_byte};
                pkt.delta_y    = {head_byte[BIT_Y_SIGN], b};
                pkt.left_btn   = head_byte[BIT_LEFT];
                pkt.right_btn  = head_byte[BIT_RIGHT];
                pkt.middle_btn = head_byte[BIT_MIDDLE];
                pkt.x_ovfl     = head_byte[BIT_X_OVFL];
                pkt.y_ovfl     = head_byte[BIT_Y_OVFL];
                packets_due.push_back(pkt);
            end
        endcase
    endtask

    function automatic int draw_wait(bit enabled);
        return enabled ? int'($urandom_range(0, 14)) : 0;
    endfunction

    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = draw_wait(send_gaps);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        decode_mouse_byte(b);
    endtask

    task automatic send_packet(logic [7:0] head, logic [7:0] xb, logic [7:0] yb);
        send_byte(head);
        send_byte(xb);
        send_byte(yb);
    endtask

    // Hold the input side and wait until every queued packet has come out.
    task automatic drain_packets();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (packets_due.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // Write a resolution register, then read it back.
    task automatic set_resolution(reg_index_t r, logic [COORD_W-1:0] v);
        drain_packets();
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= APB_DATA_W'(v);
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (r == REG_X_RES) x_res = v;
        else y_res = v;
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== APB_DATA_W'(v)) report("register readback", int'(prdata), int'(v));
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result side: random stall before each transfer while recv_gaps is set.
    initial begin
        int stall;
        forever begin
            stall = draw_wait(recv_gaps);
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    always @(posedge aclk) begin : packet_check
        mouse_packet_t got;
        mouse_packet_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.cursor_x   = m_tdata[11:0];
            got.cursor_y   = m_tdata[23:12];
            got.delta_x    = m_tdata[32:24];
            got.delta_y    = m_tdata[41:33];
            got.left_btn   = m_tdata[42];
            got.right_btn  = m_tdata[43];
            got.middle_btn = m_tdata[44];
            got.x_ovfl     = m_tdata[45];
            got.y_ovfl     = m_tdata[46];
            if (packets_due.size() == 0) begin
                report("packet with none pending", int'(m_tdata[31:0]), 0);
            end else begin
                want = packets_due.pop_front();
                if (got.cursor_x !== want.cursor_x)
                    report("cursor_x", got.cursor_x, want.cursor_x);
                if (got.cursor_y !== want.cursor_y)
                    report("cursor_y", got.cursor_y, want.cursor_y);
                if (got.delta_x !== want.delta_x)
                    report("delta_x", got.delta_x, want.delta_x);
                if (got.delta_y !== want.delta_y)
                    report("delta_y", got.delta_y, want.delta_y);
                if (got.left_btn !== want.left_btn)
                    report("left_button", got.left_btn, want.left_btn);
                if (got.right_btn !== want.right_btn)
                    report("right_button", got.right_btn, want.right_btn);
                if (got.middle_btn !== want.middle_btn)
                    report("middle_button", got.middle_btn, want.middle_btn);
                if (got.x_ovfl !== want.x_ovfl)
                    report("x_overflow", got.x_ovfl, want.x_ovfl);
                if (got.y_ovfl !== want.y_ovfl)
                    report("y_overflow", got.y_ovfl, want.y_ovfl);
            end
        end
    end

    // Drop bytes without the sync bit, then lock on the first one with it.
    task automatic test_sync_hunt();
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        send_byte(8'h00);
        send_byte(8'hF7);
        send_byte(8'h37);
        send_packet(8'h08, 8'h00, 8'h00);
    endtask

    // Buttons, signs, delta extremes, low clamp, overflow flags; the sync bit
    // is no longer required once locked.
    task automatic test_packet_fields();
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        send_packet(8'h1F, 8'h00, 8'h00);
        send_packet(8'h28, 8'hFF, 8'h00);
        send_packet(8'h07, 8'h7F, 8'hFF);
        send_gaps = 1'b1;
        send_packet(8'hC8, 8'hFF, 8'hFF);
        send_packet(8'h40, 8'h12, 8'h34);
        recv_gaps = 1'b1;
        send_packet(8'hB0, 8'h80, 8'h01);
    endtask

    // High clamp at a small and at the largest screen, and resolutions so small
    // that the back-off goes negative.
    task automatic test_resolution_extremes();
        set_resolution(REG_X_RES, 12'd32);
        set_resolution(REG_Y_RES, 12'd32);
        send_packet(8'h28, 8'hFF, 8'h00);
        send_packet(8'h30, 8'h00, 8'h00);
        set_resolution(REG_X_RES, 12'd4095);
        set_resolution(REG_Y_RES, 12'd4095);
        send_packet(8'h08, 8'hFF, 8'h00);
        send_packet(8'h20, 8'h40, 8'h00);
        set_resolution(REG_X_RES, 12'd16);
        set_resolution(REG_Y_RES, 12'd20);
        send_packet(8'h08, 8'h01, 8'h01);
        send_packet(8'h18, 8'h00, 8'h00);
    endtask

    function automatic logic [COORD_W-1:0] pick_resolution();
        case ($urandom_range(0, 3))
            0: return 12'd32;
            1: return 12'd4095;
            2: return COORD_W'($urandom_range(32, 200));
            default: return COORD_W'($urandom_range(32, 4095));
        endcase
    endfunction

    function automatic logic [7:0] pick_delta_byte();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Random packets under changing screen sizes and handshake pressure.
    task automatic test_random_traffic(int phases, int packets_per_phase);
        logic [7:0] head;
        int         hold_at;
        for (int p = 0; p < phases; p++) begin
            set_resolution(REG_X_RES, pick_resolution());
            set_resolution(REG_Y_RES, pick_resolution());
            send_gaps = ($urandom_range(0, 2) != 0);
            recv_gaps = ($urandom_range(0, 2) != 0);
            hold_at = $urandom_range(0, packets_per_phase - 1);
            for (int k = 0; k < packets_per_phase; k++) begin
                head = 8'($urandom_range(0, 255));
                // keep most packets free of overflow so the cursor moves
                if ($urandom_range(0, 7) != 0) head[7:6] = 2'b00;
                send_packet(head, pick_delta_byte(), pick_delta_byte());
                if (k == hold_at) drain_packets();
            end
        end
    endtask

    initial begin
        x_res     = X_RES_RESET;
        y_res     = Y_RES_RESET;
        synced    = 1'b0;
        byte_idx  = IDX_FIRST;
        head_byte = '0;
        x_byte    = '0;
        pos_x     = 0;
        pos_y     = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_sync_hunt();
        test_packet_fields();
        test_resolution_extremes();
        test_random_traffic(6, 33);

        drain_packets();
        repeat (8) @(posedge aclk);
        if (packets_due.size() != 0) report("packets never delivered", packets_due.size(), 0);
        if (mismatch_count == 0) begin
            $display("tb_ps2_mouse_packet_cursor: clean");
        end else begin
            $display("tb_ps2_mouse_packet_cursor: errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_ps2_mouse_packet_cursor: errors");
        $finish;
    end

endmodule
